[hdl/tcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared types and codes for the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

	// Operation codes
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_COLOR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	// Request payload
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] char_code;
		logic [7:0] color_value;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} cmd_t;

	// Result payload
	typedef struct packed {
		logic [15:0] cell_data;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [7:0]  current_color;
	} rsp_t;

	// Sequencer status toward the top level
	typedef struct packed {
		logic idle;  // able to take a request
		logic ld;    // result ready for the output register
	} ctrl_stat_t;

endpackage
`default_nettype wire

[hdl/tcw_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcw_cmd_if
// Request channel: valid/ready plus the operation fields.
// ---------------------------------------------------------------------------
interface tcw_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] char_code;
	logic [7:0] color_value;
	logic [4:0] read_row;
	logic [6:0] read_col;

	modport source (output valid, output op, output char_code, output color_value,
		output read_row, output read_col, input ready);
	modport sink (input valid, input op, input char_code, input color_value,
		input read_row, input read_col, output ready);
endinterface
`default_nettype wire

[hdl/tcw_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcw_rsp_if
// Result channel: valid/ready plus cell, cursor and colour.
// ---------------------------------------------------------------------------
interface tcw_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] cell_data;
	logic [4:0]  cursor_row;
	logic [6:0]  cursor_col;
	logic [7:0]  current_color;

	modport source (output valid, output cell_data, output cursor_row,
		output cursor_col, output current_color, input ready);
	modport sink (input valid, input cell_data, input cursor_row,
		input cursor_col, input current_color, output ready);
endinterface
`default_nettype wire

[hdl/tcw_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcw_ram
// Screen store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tcw_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [15:0]   rdata
);

	logic [15:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hdl/tcw_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcw_ctrl
// Sequencer with cursor, colour and one shared address counter that walks
// the screen store for clear, recolor and scroll.
// ---------------------------------------------------------------------------
module tcw_ctrl
	import tcw_pkg::*;
#(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire cmd_t       cmd,
	input  wire logic       out_free,
	output ctrl_stat_t      stat,
	output rsp_t            rsp_d
);

	localparam int N  = ROWS * COLS;
	localparam int AW = $clog2(N);
	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);

	localparam logic [AW-1:0] LAST      = AW'(N - 1);
	localparam logic [AW-1:0] COPY_LAST = AW'((ROWS - 1) * COLS - 1);
	localparam logic [AW-1:0] BOT       = AW'((ROWS - 1) * COLS);
	localparam logic [AW-1:0] COLS_A    = AW'(COLS);
	localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);

	// State codes
	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_PUT   = 4'd2;
	localparam logic [3:0] S_NEXT  = 4'd3;
	localparam logic [3:0] S_SWEEP = 4'd4;
	localparam logic [3:0] S_DRAIN = 4'd5;
	localparam logic [3:0] S_FILL  = 4'd6;
	localparam logic [3:0] S_RDATA = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]    state_q;
	logic [1:0]    op_q;
	logic [7:0]    char_q;
	logic [7:0]    color_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [15:0]   cell_q;
	logic [AW-1:0] ptr_q;

	// Pending write of the read-modify-write sweep
	logic          pend_s1;
	logic [AW-1:0] pend_addr_s1;

	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic [AW-1:0] raddr;
	logic [15:0]   rdata;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] rd_cmd_addr;
	logic          rd_in_range;
	logic [AW-1:0] sweep_end;

	tcw_ram #(.DEPTH(N), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Address arithmetic
	assign cur_addr    = AW'(AW'(row_q) * COLS_A) + AW'(col_q);
	assign rd_cmd_addr = AW'(AW'(cmd.read_row) * COLS_A) + AW'(cmd.read_col);
	assign rd_in_range = (32'(cmd.read_row) < ROWS) && (32'(cmd.read_col) < COLS);
	assign sweep_end   = (op_q == OP_COLOR) ? LAST : COPY_LAST;

	// Read port: sweep source while sweeping, request address otherwise
	always_comb begin
		if (state_q == S_SWEEP) begin
			raddr = (op_q == OP_COLOR) ? ptr_q : ptr_q + COLS_A;
		end else begin
			raddr = rd_cmd_addr;
		end
	end

	// Write port
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = 16'h0000;
		if (pend_s1) begin
			we    = 1'b1;
			waddr = pend_addr_s1;
			wdata = (op_q == OP_COLOR) ? {color_q, rdata[7:0]} : rdata;
		end else if (state_q == S_INIT) begin
			we = 1'b1;
		end else if (state_q == S_FILL) begin
			we    = 1'b1;
			wdata = (op_q == OP_CLEAR) ? 16'h0000 : {color_q, 8'h00};
		end else if (state_q == S_PUT) begin
			we    = 1'b1;
			waddr = cur_addr;
			wdata = {color_q, char_q};
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ptr_q   <= '0;
			pend_s1 <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
			color_q <= '0;
			op_q    <= OP_PUT;
		end else begin
			pend_s1 <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					if (ptr_q == LAST) begin
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q  <= cmd.op;
						ptr_q <= '0;
						unique case (cmd.op)
							OP_PUT: begin
								state_q <= (cmd.char_code == NEWLINE_CODE) ? S_NEXT : S_PUT;
							end
							OP_CLEAR: state_q <= S_FILL;
							OP_COLOR: begin
								color_q <= cmd.color_value;
								state_q <= S_SWEEP;
							end
							OP_READ: state_q <= rd_in_range ? S_RDATA : S_DONE;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_PUT: begin
					if (col_q == COL_LAST) begin
						state_q <= S_NEXT;
					end else begin
						col_q   <= col_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_NEXT: begin
					col_q <= '0;
					ptr_q <= '0;
					if (row_q == ROW_LAST) begin
						state_q <= S_SWEEP;
					end else begin
						row_q   <= row_q + RW'(1);
						state_q <= S_DONE;
					end
				end
				S_SWEEP: begin
					pend_s1 <= 1'b1;
					if (ptr_q == sweep_end) begin
						state_q <= S_DRAIN;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_DRAIN: begin
					ptr_q   <= BOT;
					state_q <= (op_q == OP_COLOR) ? S_DONE : S_FILL;
				end
				S_FILL: begin
					if (ptr_q == LAST) begin
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_RDATA: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		pend_addr_s1 <= ptr_q;
		if (state_q == S_IDLE && accept) begin
			char_q <= cmd.char_code;
			cell_q <= 16'h0000;
		end else if (state_q == S_RDATA) begin
			cell_q <= rdata;
		end
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.ld   = (state_q == S_DONE) && out_free;

	assign rsp_d.cell_data     = cell_q;
	assign rsp_d.cursor_row    = 5'(row_q);
	assign rsp_d.cursor_col    = 7'(col_q);
	assign rsp_d.current_color = color_q;

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !stat.idle)
		else $error("sequencer still idle after a request");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < COLS)
		else $error("cursor column out of range");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < ROWS)
		else $error("cursor row out of range");
	a_no_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && state_q == S_SWEEP) |-> (waddr != raddr))
		else $error("sweep write collides with sweep read");
	a_pend_follows_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(state_q) == S_SWEEP)
		else $error("sweep write without a sweep read");

endmodule
`default_nettype wire

[hdl/text_console_writer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// text_console_writer
// Text-mode screen store of ROWS x COLS cells with cursor and colour;
// put character, clear, set colour and read cell.
// ---------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  cmd     | in  | valid / ready | op, char_code, color_value, read_row, read_col
//  rsp     | out | valid / ready | cell_data, cursor_row, cursor_col, current_color
//
// One request at a time through a sequencer with one address counter.
// A put writes its cell and steps the cursor; a newline, or a put in the
// last column, moves to the next row, scrolling the store up one row on the
// bottom row. Clear and set colour each walk every cell of the store.
// After reset a clearing pass zeroes the store; cmd.ready stays low
// meanwhile. A result waits in the output register; the next request is
// taken while it waits and finishes when the register frees.
// ---------------------------------------------------------------------------
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tcw_cmd_if.sink    cmd,
	tcw_rsp_if.source  rsp
);

	cmd_t       cmd_s;
	ctrl_stat_t stat;
	rsp_t       rsp_d;
	rsp_t       rsp_q;
	logic       rsp_valid_q;
	logic       out_free;
	logic       accept;

	assign cmd_s.op          = cmd.op;
	assign cmd_s.char_code   = cmd.char_code;
	assign cmd_s.color_value = cmd.color_value;
	assign cmd_s.read_row    = cmd.read_row;
	assign cmd_s.read_col    = cmd.read_col;

	assign cmd.ready = stat.idle;
	assign accept    = cmd.valid && stat.idle;
	assign out_free  = !rsp_valid_q || rsp.ready;

	tcw_ctrl #(.ROWS(ROWS), .COLS(COLS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd_s),
		.out_free (out_free),
		.stat     (stat),
		.rsp_d    (rsp_d)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.ld) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.ld) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.cell_data     = rsp_q.cell_data;
	assign rsp.cursor_row    = rsp_q.cursor_row;
	assign rsp.cursor_col    = rsp_q.cursor_col;
	assign rsp.current_color = rsp_q.current_color;

	// Checks
	a_ld_free: assert property (@(posedge clk) disable iff (!arst_n)
		stat.ld |-> out_free)
		else $error("result loaded over an untaken result");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> rsp_valid_q && $stable(rsp_q))
		else $error("untaken result changed");
	a_ready_not_ld: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.ld && cmd.ready))
		else $error("request taken while a result loads");

endmodule
`default_nettype wire

[verif/text_console_writer_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. A scoreboard keeps its
// own copy of the screen, cursor and colour, works out the status of every
// accepted request and compares each returned status field by field.
// Directed requests come first, then random text lines, newline runs,
// reads near the cursor, clears, colour changes and raw noise, with random
// idling on both channels and one long output hold-off.
// ---------------------------------------------------------------------------
module text_console_writer_tb;
	import tcw_pkg::*;

	localparam int ROWS           = 25;
	localparam int COLS           = 80;
	localparam int CELLS          = ROWS * COLS;
	localparam int RANDOM_ITEMS   = 1930;
	localparam int HOLDOFF_AT     = 700;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int CALM_FROM      = 1100;
	localparam int CALM_TO        = 1400;
	localparam int DRAIN_CYCLES   = 2 * CELLS + 64;
	localparam int LIMIT_CYCLES   = 16_000_000;

	// Screen model and expected status queue
	class console_scoreboard;
		logic [15:0]  cells [CELLS];
		int unsigned  row_now;
		int unsigned  col_now;
		logic [7:0]   color_now;
		rsp_t         awaited_status [$];
		int           errors;
		int           checked;
		int           puts, newlines, clears, recolors, reads, bad_reads;
		int           scrolls, wraps;

		function new();
			for (int i = 0; i < CELLS; i++) cells[i] = '0;
			row_now   = 0;
			col_now   = 0;
			color_now = '0;
			errors    = 0;
			checked   = 0;
			puts = 0; newlines = 0; clears = 0; recolors = 0; reads = 0; bad_reads = 0;
			scrolls = 0; wraps = 0;
		endfunction

		// Move to the start of the next row, scrolling off the bottom
		function void next_line();
			col_now = 0;
			row_now++;
			if (row_now >= ROWS) begin
				row_now = ROWS - 1;
				scrolls++;
				for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
				for (int i = (ROWS - 1) * COLS; i < CELLS; i++) cells[i] = {color_now, 8'h00};
			end
		endfunction

		function void note_request(cmd_t c);
			rsp_t st;
			st.cell_data = '0;
			case (c.op)
				OP_PUT: begin
					if (c.char_code == NEWLINE_CODE) begin
						newlines++;
						next_line();
					end else begin
						puts++;
						cells[row_now * COLS + col_now] = {color_now, c.char_code};
						col_now++;
						if (col_now >= COLS) begin
							wraps++;
							next_line();
						end
					end
				end
				OP_CLEAR: begin
					clears++;
					for (int i = 0; i < CELLS; i++) cells[i] = '0;
				end
				OP_COLOR: begin
					recolors++;
					color_now = c.color_value;
					for (int i = 0; i < CELLS; i++) cells[i][15:8] = c.color_value;
				end
				default: begin
					reads++;
					if (c.read_row < ROWS && c.read_col < COLS)
						st.cell_data = cells[c.read_row * COLS + c.read_col];
					else
						bad_reads++;
				end
			endcase
			st.cursor_row    = row_now[4:0];
			st.cursor_col    = col_now[6:0];
			st.current_color = color_now;
			awaited_status.push_back(st);
		endfunction

		function void check_status(rsp_t got);
			rsp_t exp;
			if (awaited_status.size() == 0) begin
				$display("%0t: unexpected status: cell %h row %0d col %0d color %h",
					$time, got.cell_data, got.cursor_row, got.cursor_col, got.current_color);
				errors++;
				return;
			end
			exp = awaited_status.pop_front();
			checked++;
			if (got.cell_data !== exp.cell_data) begin
				$display("%0t: cell_data expected %h actual %h", $time, exp.cell_data,
					got.cell_data);
				errors++;
			end
			if (got.cursor_row !== exp.cursor_row) begin
				$display("%0t: cursor_row expected %0d actual %0d", $time, exp.cursor_row,
					got.cursor_row);
				errors++;
			end
			if (got.cursor_col !== exp.cursor_col) begin
				$display("%0t: cursor_col expected %0d actual %0d", $time, exp.cursor_col,
					got.cursor_col);
				errors++;
			end
			if (got.current_color !== exp.current_color) begin
				$display("%0t: current_color expected %h actual %h", $time, exp.current_color,
					got.current_color);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count   = 0;
	int   requests_sent = 0;
	bit   calm          = 0;
	bit   holdoff_req   = 0;

	console_scoreboard sb = new();

	tcw_cmd_if cmd_ch ();
	tcw_rsp_if rsp_ch ();

	text_console_writer #(
		.ROWS(ROWS),
		.COLS(COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d statuses still awaited", cycle_count,
				sb.awaited_status.size());
			$display("simulation failed");
			$finish;
		end
	end

	// Status monitor: values seen here are the ones before the edge
	always @(posedge clk) begin
		rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.cell_data     = rsp_ch.cell_data;
			got.cursor_row    = rsp_ch.cursor_row;
			got.cursor_col    = rsp_ch.cursor_col;
			got.current_color = rsp_ch.current_color;
			sb.check_status(got);
		end
	end

	// Output side: random stalls, one long hold-off, a calm stretch
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req && !hold_done) begin
				hold_done = 1;
				hold_left = HOLDOFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (calm) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= 32);
			end
		end
	end

	// All fields random; callers overwrite what matters
	function automatic cmd_t random_cmd(logic [1:0] op);
		cmd_t c;
		c.op          = op;
		c.char_code   = 8'($urandom_range(0, 255));
		c.color_value = 8'($urandom_range(0, 255));
		c.read_row    = 5'($urandom_range(0, 31));
		c.read_col    = 7'($urandom_range(0, 127));
		return c;
	endfunction

	// Offer one request, with random idle cycles in front, until accepted
	task automatic send_request(cmd_t c);
		while (!calm && $urandom_range(0, 99) < 32) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.op          <= c.op;
		cmd_ch.char_code   <= c.char_code;
		cmd_ch.color_value <= c.color_value;
		cmd_ch.read_row    <= c.read_row;
		cmd_ch.read_col    <= c.read_col;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_request(c);
		requests_sent++;
		if (requests_sent >= HOLDOFF_AT) holdoff_req = 1;
		calm = (requests_sent >= CALM_FROM && requests_sent < CALM_TO);
	endtask

	task automatic put_char(logic [7:0] ch);
		cmd_t c;
		c = random_cmd(OP_PUT);
		c.char_code = ch;
		send_request(c);
	endtask

	task automatic set_color(logic [7:0] attr);
		cmd_t c;
		c = random_cmd(OP_COLOR);
		c.color_value = attr;
		send_request(c);
	endtask

	task automatic read_cell(int r, int col);
		cmd_t c;
		c = random_cmd(OP_READ);
		c.read_row = 5'(r);
		c.read_col = 7'(col);
		send_request(c);
	endtask

	// Reads aimed at the cursor, the bottom row, anywhere, or out of range
	task automatic read_somewhere();
		case ($urandom_range(0, 4))
			0: read_cell($urandom_range(0, 31), $urandom_range(0, 127));
			1: read_cell(sb.row_now, (sb.col_now == 0) ? 0 : sb.col_now - 1);
			2: read_cell(ROWS - 1, $urandom_range(0, COLS - 1));
			default: read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
		endcase
	endtask

	task automatic run_directed();
		read_cell(0, 0);
		put_char(8'h41);
		put_char(8'h00);
		put_char(8'hFF);
		read_cell(0, 0);
		read_cell(0, 2);
		set_color(8'hFF);
		read_cell(0, 1);
		put_char(NEWLINE_CODE);
		put_char(8'h7E);
		read_cell(1, 0);
		read_cell(ROWS - 1, COLS - 1);
		read_cell(ROWS, 0);
		read_cell(0, COLS);
		read_cell(31, 127);
		send_request(random_cmd(OP_CLEAR));
		read_cell(1, 0);
		set_color(8'h00);
		put_char(8'h55);
		set_color(8'hA5);
		read_cell(1, 1);
	endtask

	task automatic run_random();
		int kind;
		int len;
		while (requests_sent < RANDOM_ITEMS + 21) begin
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				// text line, long enough at times to wrap
				len = $urandom_range(0, 100);
				repeat (len) begin
					if ($urandom_range(0, 3) != 0)
						put_char(8'($urandom_range(8'h20, 8'h7E)));
					else
						put_char(8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 9) < 7) put_char(NEWLINE_CODE);
			end else if (kind < 66) begin
				repeat ($urandom_range(1, 6)) read_somewhere();
			end else if (kind < 75) begin
				repeat ($urandom_range(1, 4)) put_char(NEWLINE_CODE);
			end else if (kind < 79) begin
				send_request(random_cmd(OP_CLEAR));
				read_somewhere();
			end else if (kind < 84) begin
				set_color(8'($urandom_range(0, 255)));
				read_somewhere();
			end else begin
				send_request(random_cmd(2'($urandom_range(0, 3))));
			end
		end
	endtask

	// Stimulus and end of run
	initial begin
		arst_n             <= 1'b0;
		cmd_ch.valid       <= 1'b0;
		cmd_ch.op          <= OP_PUT;
		cmd_ch.char_code   <= '0;
		cmd_ch.color_value <= '0;
		cmd_ch.read_row    <= '0;
		cmd_ch.read_col    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();
		run_random();
		cmd_ch.valid <= 1'b0;

		while (sb.awaited_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests, %0d statuses checked: %0d chars, %0d newlines, %0d clears,",
			requests_sent, sb.checked, sb.puts, sb.newlines, sb.clears);
		$display("%0d colour changes, %0d reads (%0d out of range), %0d wraps, %0d scrolls",
			sb.recolors, sb.reads, sb.bad_reads, sb.wraps, sb.scrolls);
		if (sb.errors == 0 && sb.awaited_status.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[text_console_writer.f]
hdl/tcw_pkg.sv
hdl/tcw_cmd_if.sv
hdl/tcw_rsp_if.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer.sv
verif/text_console_writer_tb.sv
